// File: design/rrfp_pkg.sv
// shared types and constants for the radar report frame parser
`default_nettype none

package rrfp_pkg;

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_LEN  = 3'b010,
        PH_BODY = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_TYPE     = 2'd2,
        ST_OVERSIZE = 2'd3
    } status_t;

    localparam int          REC_BYTES      = 9;
    localparam logic [6:0]  LEN_LOW_POS    = 7'd4;
    localparam logic [6:0]  LEN_HIGH_POS   = 7'd5;
    localparam logic [6:0]  TYPE_HI_POS    = 7'd6;
    localparam logic [6:0]  TYPE_LO_POS    = 7'd7;
    localparam logic [6:0]  REC_FIRST_POS  = 7'd8;
    localparam logic [6:0]  MIN_FRAME      = 7'd20;
    localparam logic [8:0]  FRAME_OVERHEAD = 9'd10;
    localparam logic [7:0]  TYPE_HI        = 8'h02;
    localparam logic [7:0]  TYPE_LO        = 8'hAA;
    localparam logic [7:0]  HDR_FIRST      = 8'hF4;
    localparam int          TDATA_OUT_W    = 80;

    function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'hF4;
            2'd1:    val = 8'hF3;
            2'd2:    val = 8'hF2;
            default: val = 8'hF1;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// File: design/radar_report_frame_parser_unit.sv
// radar report frame parser: header hunt, length count, record capture
//
// usage notes
// - input stream s_axis_*: one received serial byte per item in tdata[7:0]
// - output stream m_axis_*: one result item at the last byte of each frame,
//   or at the second length byte when the length is oversized; carries the
//   frame status and the record of the last accepted frame
// - every byte is handled by the parse registers; a result appears on
//   m_axis in the cycle after the byte that ends the frame
// - throughput is one byte per cycle; the single result register sets it,
//   the input is taken whenever that register is empty or being drained
// - while the receiver stalls with a result pending, s_axis_tready is low
//   and no byte is taken; nothing is dropped
// - reset returns the parser to header hunting and clears the held record
//   to zero, so results before any accepted frame report zero fields
// - MAX_FRAME_BYTES (20 to 127) is the largest frame, header included,
//   that is still parsed; longer frames report oversized at once
`default_nettype none

module radar_report_frame_parser_unit
    import rrfp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [7:0] rx_byte
    input  wire logic [7:0]             s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [1:0] frame_status, [9:2] presence_state, [25:10] moving_distance,
    // [33:26] moving_energy, [49:34] still_distance, [57:50] still_energy,
    // [73:58] detection_distance, [79:74] zero
    output logic [TDATA_OUT_W-1:0]      m_axis_tdata
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  matched_reg, matched_next;
    logic [6:0]  pos_reg, pos_next;
    logic [6:0]  total_reg, total_next;
    logic [7:0]  len_low_reg, len_low_next;
    logic [7:0]  type_hi_reg;
    logic [7:0]  type_lo_reg;
    logic [7:0]  pending_reg [REC_BYTES];
    logic [7:0]  held_reg [REC_BYTES];
    logic        out_valid_reg, out_valid_next;
    status_t     status_reg, status_next;

    logic        in_accept;
    logic        emit;
    logic        commit;
    logic [7:0]  rx;
    logic [8:0]  total_sum;
    logic        oversize;
    logic        frame_end;

    assign rx            = s_axis_tdata;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign total_sum = {1'b0, len_low_reg} + FRAME_OVERHEAD;
    assign oversize  = (rx != 8'd0) || (total_sum > 9'(MAX_FRAME_BYTES));
    assign frame_end = ({1'b0, pos_reg} + 8'd1) >= {1'b0, total_reg};

    always_comb
    begin
        phase_next   = phase_reg;
        matched_next = matched_reg;
        pos_next     = pos_reg;
        total_next   = total_reg;
        len_low_next = len_low_reg;
        emit         = 1'b0;
        commit       = 1'b0;
        status_next  = status_reg;
        if (in_accept)
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    if (pos_reg == LEN_LOW_POS)
                    begin
                        len_low_next = rx;
                        pos_next     = LEN_HIGH_POS;
                    end
                    else if (oversize)
                    begin
                        phase_next   = PH_HUNT;
                        matched_next = 2'd0;
                        pos_next     = 7'd0;
                        emit         = 1'b1;
                        status_next  = ST_OVERSIZE;
                    end
                    else
                    begin
                        total_next = total_sum[6:0];
                        pos_next   = TYPE_HI_POS;
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (frame_end)
                    begin
                        if (total_reg < MIN_FRAME)
                            status_next = ST_SHORT;
                        else if (type_hi_reg != TYPE_HI || type_lo_reg != TYPE_LO)
                            status_next = ST_TYPE;
                        else
                        begin
                            status_next = ST_OK;
                            commit      = 1'b1;
                        end
                        phase_next   = PH_HUNT;
                        matched_next = 2'd0;
                        pos_next     = 7'd0;
                        emit         = 1'b1;
                    end
                    else
                        pos_next = pos_reg + 7'd1;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    if (rx == hdr_byte(matched_reg))
                    begin
                        if (matched_reg == 2'd3)
                        begin
                            matched_next = 2'd0;
                            phase_next   = PH_LEN;
                            pos_next     = LEN_LOW_POS;
                        end
                        else
                            matched_next = matched_reg + 2'd1;
                    end
                    else
                        // a stray first header byte restarts the match at one
                        matched_next = (rx == HDR_FIRST) ? 2'd1 : 2'd0;
                end
            endcase
        end
    end

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            matched_reg   <= 2'd0;
            pos_reg       <= 7'd0;
            total_reg     <= 7'd0;
            len_low_reg   <= 8'd0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
        end
        else
        begin
            phase_reg     <= phase_next;
            matched_reg   <= matched_next;
            pos_reg       <= pos_next;
            total_reg     <= total_next;
            len_low_reg   <= len_low_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
        end
    end

    // capture of type bytes and record bytes, and commit of the record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_hi_reg <= 8'd0;
            type_lo_reg <= 8'd0;
            for (int i = 0; i < REC_BYTES; i++)
            begin
                pending_reg[i] <= 8'd0;
                held_reg[i]    <= 8'd0;
            end
        end
        else
        begin
            if (in_accept && phase_reg == PH_BODY)
            begin
                if (pos_reg == TYPE_HI_POS)
                    type_hi_reg <= rx;
                if (pos_reg == TYPE_LO_POS)
                    type_lo_reg <= rx;
                for (int i = 0; i < REC_BYTES; i++)
                begin
                    if (pos_reg == REC_FIRST_POS + 7'(i))
                        pending_reg[i] <= rx;
                end
            end
            if (commit)
            begin
                for (int i = 0; i < REC_BYTES; i++)
                    held_reg[i] <= pending_reg[i];
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0,
                            held_reg[8], held_reg[7],
                            held_reg[6],
                            held_reg[5], held_reg[4],
                            held_reg[3],
                            held_reg[2], held_reg[1],
                            held_reg[0],
                            status_reg};

`ifndef SYNTHESIS
    a_held_stable_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_body_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |->
            (total_reg >= 7'd10 && pos_reg < total_reg && pos_reg >= TYPE_HI_POS))
        else $error("body position outside frame");

    a_len_position: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LEN) |-> (pos_reg == LEN_LOW_POS || pos_reg == LEN_HIGH_POS))
        else $error("length phase at wrong position");

    a_commit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || m_axis_tready))
        else $error("result produced with output register full");
`endif

endmodule

`default_nettype wire

// File: tb/rrfp_frame_checker.sv
// frame checker: predicts parser results from input items and compares output items
`timescale 1ns / 100ps

module rrfp_frame_checker
    import rrfp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_ready,
    input  wire logic [7:0]             in_data,
    input  wire logic                   out_valid,
    input  wire logic                   out_ready,
    input  wire logic [TDATA_OUT_W-1:0] out_data,
    output int                          error_total,
    output int                          results_waiting
);

    // layout of one result item, lowest field last
    typedef struct packed {
        logic [5:0]  pad;
        logic [15:0] det_dist;
        logic [7:0]  still_en;
        logic [15:0] still_dist;
        logic [7:0]  mov_en;
        logic [15:0] mov_dist;
        logic [7:0]  tgt;
        logic [1:0]  status;
    } frame_result_t;

    localparam logic [31:0] HDR_SEQ = 32'hF1F2F3F4;

    phase_t       phase;
    logic [1:0]   hdr_cnt;
    logic [6:0]   pos;
    logic [6:0]   frame_len;
    logic [7:0]   len_lo;
    logic [7:0]   type_hi_b;
    logic [7:0]   type_lo_b;
    logic [7:0]   pend_rec [REC_BYTES];
    logic [7:0]   held_rec [REC_BYTES];
    int           mismatches;

    frame_result_t frame_results_q [$];

    function automatic frame_result_t held_result(input status_t st);
        frame_result_t r;
        r.pad        = '0;
        r.status     = st;
        r.tgt        = held_rec[0];
        r.mov_dist   = {held_rec[2], held_rec[1]};
        r.mov_en     = held_rec[3];
        r.still_dist = {held_rec[5], held_rec[4]};
        r.still_en   = held_rec[6];
        r.det_dist   = {held_rec[8], held_rec[7]};
        return r;
    endfunction

    task automatic parse_byte(input logic [7:0] b);
        int      total;
        status_t st;
        case (phase)
            PH_LEN:
            begin
                if (pos == LEN_LOW_POS)
                begin
                    len_lo = b;
                    pos    = LEN_HIGH_POS;
                end
                else
                begin
                    total = 10 + int'({b, len_lo});
                    if (total > MAX_FRAME_BYTES)
                    begin
                        phase   = PH_HUNT;
                        hdr_cnt = 2'd0;
                        pos     = 7'd0;
                        frame_results_q.push_back(held_result(ST_OVERSIZE));
                    end
                    else
                    begin
                        frame_len = total[6:0];
                        pos       = TYPE_HI_POS;
                        phase     = PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                if (pos == TYPE_HI_POS)
                    type_hi_b = b;
                else if (pos == TYPE_LO_POS)
                    type_lo_b = b;
                else if (pos >= REC_FIRST_POS && pos < REC_FIRST_POS + REC_BYTES)
                    pend_rec[4'(pos - REC_FIRST_POS)] = b;
                if (int'(pos) + 1 >= int'(frame_len))
                begin
                    if (frame_len < MIN_FRAME)
                        st = ST_SHORT;
                    else if (type_hi_b != TYPE_HI || type_lo_b != TYPE_LO)
                        st = ST_TYPE;
                    else
                    begin
                        held_rec = pend_rec;
                        st = ST_OK;
                    end
                    phase   = PH_HUNT;
                    hdr_cnt = 2'd0;
                    pos     = 7'd0;
                    frame_results_q.push_back(held_result(st));
                end
                else
                    pos = pos + 7'd1;
            end
            default:
            begin
                phase = PH_HUNT;
                if (b == HDR_SEQ[8*hdr_cnt +: 8])
                begin
                    if (hdr_cnt == 2'd3)
                    begin
                        hdr_cnt = 2'd0;
                        phase   = PH_LEN;
                        pos     = LEN_LOW_POS;
                    end
                    else
                        hdr_cnt = hdr_cnt + 2'd1;
                end
                else
                    hdr_cnt = (b == HDR_FIRST) ? 2'd1 : 2'd0;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t exp_r;
        frame_result_t got_r;
        if (!rst_n)
        begin
            phase     = PH_HUNT;
            hdr_cnt   = 2'd0;
            pos       = 7'd0;
            frame_len = 7'd0;
            len_lo    = 8'd0;
            type_hi_b = 8'd0;
            type_lo_b = 8'd0;
            for (int i = 0; i < REC_BYTES; i++)
            begin
                pend_rec[i] = 8'd0;
                held_rec[i] = 8'd0;
            end
            frame_results_q.delete();
            mismatches      = 0;
            error_total     <= 0;
            results_waiting <= 0;
        end
        else
        begin
            // a result never stems from the item taken at the same edge
            if (out_valid && out_ready)
            begin
                got_r = frame_result_t'(out_data);
                if (frame_results_q.size() == 0)
                begin
                    $error("result item with no frame pending, tdata %0h", out_data);
                    mismatches++;
                end
                else
                begin
                    exp_r = frame_results_q.pop_front();
                    check_field("frame_status", 16'(exp_r.status), 16'(got_r.status));
                    check_field("presence_state", 16'(exp_r.tgt), 16'(got_r.tgt));
                    check_field("moving_distance", exp_r.mov_dist, got_r.mov_dist);
                    check_field("moving_energy", 16'(exp_r.mov_en), 16'(got_r.mov_en));
                    check_field("still_distance", exp_r.still_dist, got_r.still_dist);
                    check_field("still_energy", 16'(exp_r.still_en),
                                16'(got_r.still_en));
                    check_field("detection_distance", exp_r.det_dist, got_r.det_dist);
                    check_field("tdata padding", 16'(exp_r.pad), 16'(got_r.pad));
                end
            end
            if (in_valid && in_ready)
                parse_byte(in_data);
            error_total     <= mismatches;
            results_waiting <= frame_results_q.size();
        end
    end

endmodule

// File: tb/radar_report_frame_parser_unit_tb.sv
// top of the frame parser testbench: clock, reset, byte stimulus and verdict
`timescale 1ns / 100ps

module radar_report_frame_parser_unit_tb
    import rrfp_pkg::*;
();

    localparam int MAX_FRAME = 64;
    localparam int ITEMS     = 1150;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = 8'd0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;

    int error_total;
    int results_waiting;
    int src_idle = 36;
    int sink_idle = 52;
    int frame_bytes = 0;

    radar_report_frame_parser_unit #(
        .MAX_FRAME_BYTES(MAX_FRAME)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    rrfp_frame_checker #(
        .MAX_FRAME_BYTES(MAX_FRAME)
    ) frame_chk (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .in_data(s_axis_tdata),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data(m_axis_tdata),
        .error_total(error_total),
        .results_waiting(results_waiting)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= sink_idle);
    end

    // one byte item; tvalid stays high into the next call unless it idles
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    function automatic logic [7:0] data_byte();
        logic [7:0] b;
        case ($urandom_range(7))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            2:       b = HDR_FIRST;
            default: b = 8'($urandom_range(255));
        endcase
        return b;
    endfunction

    // header, length, and the body unless the length is oversized
    task automatic send_frame(input logic [15:0] len, input logic [7:0] thi,
                              input logic [7:0] tlo);
        int total;
        int p;
        total = 10 + int'(len);
        push_byte(8'hF4);
        push_byte(8'hF3);
        push_byte(8'hF2);
        push_byte(8'hF1);
        push_byte(len[7:0]);
        push_byte(len[15:8]);
        frame_bytes += 6;
        if (total <= MAX_FRAME)
        begin
            for (p = 6; p < total; p++)
            begin
                if (p == 6)
                    push_byte(thi);
                else if (p == 7)
                    push_byte(tlo);
                else
                    push_byte(data_byte());
            end
            frame_bytes += total - 6;
        end
    endtask

    initial
    begin
        logic [15:0] len;
        logic [7:0]  thi;
        logic [7:0]  tlo;
        int          n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // stray F4 restarts the header, then an all-ones length is oversized
        push_byte(8'hF4);
        push_byte(8'hF4);
        push_byte(8'hF3);
        push_byte(8'hF2);
        push_byte(8'hF1);
        push_byte(8'hFF);
        push_byte(8'hFF);
        // empty payload: short even with wrong type, F4 inside is plain data
        send_frame(16'd0, HDR_FIRST, HDR_FIRST);
        // broken header falls back to hunting
        push_byte(8'hF4);
        push_byte(8'hF3);
        push_byte(8'h00);
        // first length that no longer fits
        send_frame(16'(MAX_FRAME - 9), TYPE_HI, TYPE_LO);

        while (frame_bytes < ITEMS)
        begin
            if (frame_bytes < ITEMS / 3)
            begin
                src_idle  = 36;
                sink_idle = 52;
            end
            else if (frame_bytes < 2 * ITEMS / 3)
            begin
                src_idle  = 52;
                sink_idle = 36;
            end
            else
            begin
                src_idle  = 0;
                sink_idle = 0;
            end
            n = $urandom_range(99);
            if (n < 50)
            begin
                case ($urandom_range(5))
                    0:       len = 16'd10;
                    1:       len = 16'(MAX_FRAME - 10);
                    default: len = 16'($urandom_range(10, 30));
                endcase
                send_frame(len, TYPE_HI, TYPE_LO);
            end
            else if (n < 62)
            begin
                thi = $urandom_range(1) ? TYPE_HI : data_byte();
                send_frame(16'($urandom_range(0, 9)), thi, TYPE_LO);
            end
            else if (n < 74)
            begin
                thi = TYPE_HI;
                tlo = TYPE_LO;
                case ($urandom_range(2))
                    0:       thi = TYPE_HI ^ (8'd1 << $urandom_range(7));
                    1:       tlo = TYPE_LO ^ (8'd1 << $urandom_range(7));
                    default:
                    begin
                        thi = data_byte();
                        tlo = data_byte();
                    end
                endcase
                send_frame(16'($urandom_range(10, MAX_FRAME - 10)), thi, tlo);
            end
            else if (n < 84)
            begin
                case ($urandom_range(3))
                    0:       len = 16'(MAX_FRAME - 9);
                    1:       len = 16'($urandom_range(MAX_FRAME - 8, 255));
                    2:       len = {8'($urandom_range(1, 255)), 8'($urandom_range(255))};
                    default: len = 16'hFFFF;
                endcase
                send_frame(len, TYPE_HI, TYPE_LO);
            end
            else if (n < 92)
            begin
                // partial header, then a restart or a plain byte
                push_byte(8'hF4);
                if ($urandom_range(1))
                    push_byte(8'hF3);
                if ($urandom_range(1))
                    push_byte(8'hF2);
                push_byte($urandom_range(2) == 0 ? HDR_FIRST : 8'($urandom_range(8'hEF)));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    push_byte(8'($urandom_range(8'hEF)));
            end
        end
        s_axis_tvalid <= 1'b0;

        repeat (2) @(posedge clk);
        while (results_waiting != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_total == 0 && results_waiting == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
